// ----- src/gcrd_pkg.sv -----
// Shared types and constants for the great-circle route distance block.
// Depends on nothing; used by the top level, its checker and the testbench.
package gcrd_pkg;

    // Datapath widths.
    localparam int CordicW = 36;   // CORDIC x and y
    localparam int AngleW  = 34;   // CORDIC z, signed binary angle with headroom
    localparam int OperW   = 34;   // signed multiplier operand
    localparam int ProdW   = 68;   // signed multiplier product
    localparam int IterW   = 6;    // step counter, indexes the 40-entry atan table
    localparam int AtanLen = 40;
    localparam int SqrtSteps = 32;

    // Field widths.
    localparam int LegW   = 30;
    localparam int TotalW = 40;
    localparam int RadW   = 12;

    localparam logic [RadW-1:0] RadiusReset = 12'd3440;

    // Fixed-point constants.
    localparam logic [31:0] CordicGainQ30 = 32'd652032874;
    localparam logic [28:0] PiQ27         = 29'd421657428;
    localparam logic [19:0] FeetToNmQ32   = 20'd706861;
    localparam logic [AngleW-1:0] QuarterTurn = 34'sd1073741824;
    localparam logic [AngleW-1:0] HalfTurn    = 34'sd2147483648;

    // Arctangent of 2^-i in 2^-31 half-turn units.
    localparam logic [31:0] AtanUnits [AtanLen] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
        32'd20, 32'd10, 32'd5, 32'd3, 32'd1,
        32'd1, 32'd0, 32'd0, 32'd0, 32'd0,
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0
    };

endpackage

// ----- src/great_circle_route_distance.sv -----
// Great-circle route distance accumulator, top level.
// Depends on gcrd_pkg for widths, fixed-point constants and the atan table.

// Waypoints are taken one item at a time and each produces one result item.
// The first waypoint of a route goes from capture straight to the output
// stage. Every later waypoint runs through one shared CORDIC step unit
// that runs three sine/cosine passes and one atan2 pass, a 32-step square
// root, and one shared multiplier that serves twelve products. The input
// stalls while a waypoint is in work. A finished result waits in the output
// register, and the next waypoint is taken while it waits.
module great_circle_route_distance #(
    parameter int CORDIC_STEPS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration
    input  logic                         i_cfg_we,
    input  logic [gcrd_pkg::RadW-1:0]    i_cfg_data,
    // Waypoint input
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [31:0]           i_latitude,
    input  logic signed [31:0]           i_longitude,
    input  logic [16:0]                  i_height_feet,
    input  logic                         i_route_last,
    // Result output
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [gcrd_pkg::LegW-1:0]    o_leg_distance,
    output logic [gcrd_pkg::TotalW-1:0]  o_total_distance,
    output logic                         o_route_done
);

    localparam int DW = gcrd_pkg::CordicW;
    localparam int ZW = gcrd_pkg::AngleW;
    localparam int MW = gcrd_pkg::OperW;
    localparam int PW = gcrd_pkg::ProdW;
    localparam int IW = gcrd_pkg::IterW;

    typedef enum logic [2:0] {
        S_IDLE, S_SC_INIT, S_CORDIC, S_MUL, S_MULW, S_SQRT, S_FIN
    } t_state;

    typedef enum logic [1:0] {SEL_LAT1, SEL_LAT2, SEL_DLON} t_sel;

    typedef enum logic [3:0] {
        M_T, M_A, M_P, M_P2, M_D1, M_D2, M_AA, M_BB, M_HQ, M_AR, M_QL, M_QH
    } t_mstep;

    t_state r_state;
    t_sel   r_sel;
    t_mstep r_mstep;

    logic [gcrd_pkg::RadW-1:0] r_radius_nm;

    // Route state.
    logic signed [31:0] r_prev_lat, r_prev_lon;
    logic [16:0]        r_prev_h;
    logic               r_have_prev;
    logic [gcrd_pkg::TotalW-1:0] r_total;

    // Captured waypoint.
    logic signed [31:0] r_lat, r_lon;
    logic [16:0]        r_h;
    logic               r_last;

    // CORDIC unit.
    logic signed [DW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic                 r_rot, r_neg;
    logic [IW-1:0]        r_iter;

    // Trig results and Vincenty terms.
    logic signed [MW-1:0] r_s1, r_c1, r_s2, r_c2, r_sd, r_cd;
    logic signed [MW-1:0] r_t, r_a, r_b, r_den;

    // Square root.
    logic [63:0] r_v, r_r, r_bit;

    // Distance terms.
    logic signed [PW-1:0] r_prod;
    logic [31:0]          r_ang;
    logic [28:0]          r_rad;
    logic [35:0]          r_q;
    logic [47:0]          r_acc;
    logic [gcrd_pkg::LegW-1:0] r_leg;

    // One CORDIC step: sigma positive means x - y*2^-i, y + x*2^-i, z - atan.
    logic signed [DW-1:0] xs, ys, n_x, n_y;
    logic signed [ZW-1:0] at, n_z;
    logic                 sigma_pos;

    always_comb begin
        xs = r_x >>> r_iter;
        ys = r_y >>> r_iter;
        at = ZW'(gcrd_pkg::AtanUnits[r_iter]);
        sigma_pos = r_rot ? !r_z[ZW-1] : r_y[DW-1];
        if (sigma_pos) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - at;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + at;
        end
    end

    // Angle for the next sine/cosine pass, folded into the right half-plane.
    logic signed [31:0]   sc_ang;
    logic signed [ZW-1:0] sc_z0, sc_z;
    logic                 sc_neg;

    always_comb begin
        case (r_sel)
            SEL_LAT1: sc_ang = r_prev_lat;
            SEL_LAT2: sc_ang = r_lat;
            SEL_DLON: sc_ang = r_lon - r_prev_lon;
            default:  sc_ang = r_lat;
        endcase
        sc_z0 = ZW'(sc_ang);
        sc_neg = 1'b0;
        sc_z = sc_z0;
        if (sc_z0 > signed'(gcrd_pkg::QuarterTurn)) begin
            sc_z = sc_z0 - signed'(gcrd_pkg::HalfTurn);
            sc_neg = 1'b1;
        end else if (sc_z0 < -signed'(gcrd_pkg::QuarterTurn)) begin
            sc_z = sc_z0 + signed'(gcrd_pkg::HalfTurn);
            sc_neg = 1'b1;
        end
    end

    // Clamped atan2 result of a finished vectoring pass.
    logic [31:0] ang_clamped;
    always_comb begin
        if (r_z[ZW-1]) begin
            ang_clamped = '0;
        end else if (r_z > signed'(gcrd_pkg::HalfTurn)) begin
            ang_clamped = 32'h8000_0000;
        end else begin
            ang_clamped = r_z[31:0];
        end
    end

    // One square-root step.
    logic [63:0] sq_sum, n_v, n_r;
    always_comb begin
        sq_sum = r_r + r_bit;
        if (r_v >= sq_sum) begin
            n_v = r_v - sq_sum;
            n_r = (r_r >> 1) + r_bit;
        end else begin
            n_v = r_v;
            n_r = r_r >> 1;
        end
    end

    // Operand selection for the shared multiplier.
    logic signed [MW-1:0] ma, mb, abs_a, abs_b;
    assign abs_a = r_a[MW-1] ? -r_a : r_a;
    assign abs_b = r_b[MW-1] ? -r_b : r_b;

    always_comb begin
        case (r_mstep)
            M_T:  begin ma = r_c2; mb = r_cd; end
            M_A:  begin ma = r_c1; mb = r_sd; end
            M_P:  begin ma = r_c1; mb = r_s2; end
            M_P2: begin ma = r_s1; mb = r_t;  end
            M_D1: begin ma = r_s1; mb = r_s2; end
            M_D2: begin ma = r_c1; mb = r_t;  end
            M_AA: begin ma = abs_a; mb = abs_a; end
            M_BB: begin ma = abs_b; mb = abs_b; end
            M_HQ: begin ma = MW'(r_prev_h); mb = MW'(gcrd_pkg::FeetToNmQ32); end
            M_AR: begin ma = MW'(r_ang); mb = MW'(r_rad); end
            M_QL: begin ma = MW'(r_q[17:0]); mb = MW'(gcrd_pkg::PiQ27); end
            M_QH: begin ma = MW'(r_q[35:18]); mb = MW'(gcrd_pkg::PiQ27); end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    // Views of the registered product.
    logic signed [PW-1:0] prod_q30;
    logic [37:0]          hq_sum;
    logic [28:0]          rad_next;
    logic [66:0]          leg_sum;
    logic [40:0]          total_sum;

    assign prod_q30  = r_prod >>> 30;
    assign hq_sum    = r_prod[37:0] + 38'd32768;
    assign rad_next  = 29'({r_radius_nm, 16'd0}) + 29'(hq_sum[37:16]);
    assign leg_sum   = {r_prod[48:0], 18'd0} + 67'(r_acc) + (67'd1 << 33);
    assign total_sum = 41'(r_total) + 41'(r_leg);

    assign o_in_stall = (r_state != S_IDLE);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_nm <= gcrd_pkg::RadiusReset;
        end else if (i_cfg_we) begin
            r_radius_nm <= i_cfg_data;
        end
    end

    // Sequencer, datapath registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= SEL_LAT1;
            r_mstep     <= M_T;
            r_iter      <= '0;
            r_rot       <= 1'b1;
            r_neg       <= 1'b0;
            r_have_prev <= 1'b0;
            r_prev_lat  <= '0;
            r_prev_lon  <= '0;
            r_prev_h    <= '0;
            r_total     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_lat  <= i_latitude;
                        r_lon  <= i_longitude;
                        r_h    <= i_height_feet;
                        r_last <= i_route_last;
                        r_leg  <= '0;
                        r_sel  <= SEL_LAT1;
                        r_state <= r_have_prev ? S_SC_INIT : S_FIN;
                    end
                end
                S_SC_INIT: begin
                    r_x    <= DW'(gcrd_pkg::CordicGainQ30);
                    r_y    <= '0;
                    r_z    <= sc_z;
                    r_neg  <= sc_neg;
                    r_rot  <= 1'b1;
                    r_iter <= '0;
                    r_state <= S_CORDIC;
                end
                S_CORDIC: begin
                    r_x <= n_x;
                    r_y <= n_y;
                    r_z <= n_z;
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == IW'(CORDIC_STEPS - 1)) begin
                        if (r_rot) begin
                            // The pass result is taken from the last step's values.
                            r_state <= S_SC_INIT;
                            case (r_sel)
                                SEL_LAT1: begin
                                    r_s1 <= MW'(r_neg ? -n_y : n_y);
                                    r_c1 <= MW'(r_neg ? -n_x : n_x);
                                    r_sel <= SEL_LAT2;
                                end
                                SEL_LAT2: begin
                                    r_s2 <= MW'(r_neg ? -n_y : n_y);
                                    r_c2 <= MW'(r_neg ? -n_x : n_x);
                                    r_sel <= SEL_DLON;
                                end
                                default: begin
                                    r_sd <= MW'(r_neg ? -n_y : n_y);
                                    r_cd <= MW'(r_neg ? -n_x : n_x);
                                    r_mstep <= M_T;
                                    r_state <= S_MUL;
                                end
                            endcase
                        end else begin
                            r_mstep <= M_HQ;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    // Clamp the atan2 result once the vectoring pass has ended.
                    if (r_mstep == M_HQ) begin
                        r_ang <= ang_clamped;
                    end
                    r_prod  <= ma * mb;
                    r_state <= S_MULW;
                end
                S_MULW: begin
                    r_state <= S_MUL;
                    r_mstep <= t_mstep'(r_mstep + 1'b1);
                    case (r_mstep)
                        M_T:  r_t   <= prod_q30[MW-1:0];
                        M_A:  r_a   <= prod_q30[MW-1:0];
                        M_P:  r_b   <= prod_q30[MW-1:0];
                        M_P2: r_b   <= r_b - prod_q30[MW-1:0];
                        M_D1: r_den <= prod_q30[MW-1:0];
                        M_D2: r_den <= r_den + prod_q30[MW-1:0];
                        M_AA: r_v   <= r_prod[63:0];
                        M_BB: begin
                            r_v     <= r_v + r_prod[63:0];
                            r_r     <= '0;
                            r_bit   <= 64'd1 << 62;
                            r_iter  <= '0;
                            r_state <= S_SQRT;
                        end
                        M_HQ: r_rad <= rad_next;
                        M_AR: r_q   <= r_prod[59:24];
                        M_QL: r_acc <= r_prod[47:0];
                        M_QH: begin
                            r_leg   <= leg_sum[63:34];
                            r_state <= S_FIN;
                        end
                        default: r_state <= S_FIN;
                    endcase
                end
                S_SQRT: begin
                    r_v    <= n_v;
                    r_r    <= n_r;
                    r_bit  <= r_bit >> 2;
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == IW'(gcrd_pkg::SqrtSteps - 1)) begin
                        // Start atan2 of (chord, denominator) by vectoring.
                        r_rot  <= 1'b0;
                        r_iter <= '0;
                        if (r_den[MW-1]) begin
                            r_x <= DW'(n_r);
                            r_y <= -DW'(r_den);
                            r_z <= gcrd_pkg::QuarterTurn;
                        end else begin
                            r_x <= DW'(r_den);
                            r_y <= DW'(n_r);
                            r_z <= '0;
                        end
                        r_state <= S_CORDIC;
                    end
                end
                S_FIN: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid    <= 1'b1;
                        o_leg_distance <= r_leg;
                        o_route_done   <= r_last;
                        o_total_distance <= total_sum[40] ? '1 : total_sum[39:0];
                        if (r_last) begin
                            r_prev_lat  <= '0;
                            r_prev_lon  <= '0;
                            r_prev_h    <= '0;
                            r_have_prev <= 1'b0;
                            r_total     <= '0;
                        end else begin
                            r_prev_lat  <= r_lat;
                            r_prev_lon  <= r_lon;
                            r_prev_h    <= r_h;
                            r_have_prev <= 1'b1;
                            r_total     <= total_sum[40] ? '1 : total_sum[39:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- src/gcrd_checker.sv -----
// Port-level checks for the great-circle route distance block, and the bind
// that attaches them. Depends on gcrd_pkg for field widths.
module gcrd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [gcrd_pkg::LegW-1:0]    o_leg_distance,
    input logic [gcrd_pkg::TotalW-1:0]  o_total_distance,
    input logic                         o_route_done
);

    // A stalled result item holds its place and value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_leg_distance)
            && $stable(o_total_distance) && $stable(o_route_done))
        else $error("stalled result item changed");

    // An accepted waypoint keeps the block busy in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block not busy after accepting an item");

    // Reset leaves the block empty and ready.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

    // The running total always covers the leg just added.
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_total_distance >= 40'(o_leg_distance)
            || !o_route_done && o_leg_distance == '0)
        else $error("total below leg distance");

endmodule

bind great_circle_route_distance gcrd_checker u_gcrd_checker (.*);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the great-circle route distance block.
// Depends on gcrd_pkg and great_circle_route_distance; predicts each result item
// with a fixed-point CORDIC model of its own and checks every field in order.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  Steps       = 32;
    localparam int  StallLimit  = 4000;
    localparam longint Quarter  = 64'sd1073741824;
    localparam longint Half     = 64'sd2147483648;
    localparam bit [63:0] TotalMax = 64'hFF_FFFF_FFFF;

    typedef struct packed {
        logic [gcrd_pkg::LegW-1:0]   leg;
        logic [gcrd_pkg::TotalW-1:0] total;
        logic                        done;
    } t_route_result;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [gcrd_pkg::RadW-1:0]         i_cfg_data = '0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic signed [31:0]                i_latitude = '0;
    logic signed [31:0]                i_longitude = '0;
    logic [16:0]                       i_height_feet = '0;
    logic                              i_route_last = 1'b0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic [gcrd_pkg::LegW-1:0]         o_leg_distance;
    logic [gcrd_pkg::TotalW-1:0]       o_total_distance;
    logic                              o_route_done;

    // Predictor state, mirrors what the block holds between waypoints.
    bit [11:0]     radius_nm = gcrd_pkg::RadiusReset;
    longint        last_lat, last_lon;
    bit [16:0]     last_height;
    bit            route_open;
    bit [63:0]     route_total;

    t_route_result pending_legs[$];
    int            mismatches = 0;
    int            sender_idle_pct = 0;
    int            receiver_stall_pct = 0;
    int            quiet_cycles = 0;

    great_circle_route_distance #(.CORDIC_STEPS(Steps)) i_dut (.*);

    always #4 i_clk = ~i_clk;

    // CORDIC rotation: sine and cosine in Q30 of a binary angle.
    function automatic void rotate_angle(input longint ang, output longint s,
                                         output longint c);
        longint x, y, z, nx;
        bit neg;
        x = 652032874; y = 0; z = ang; neg = 0;
        if (z > Quarter) begin
            z -= Half; neg = 1;
        end else if (z < -Quarter) begin
            z += Half; neg = 1;
        end
        for (int i = 0; i < Steps; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(gcrd_pkg::AtanUnits[i]);
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z += longint'(gcrd_pkg::AtanUnits[i]);
            end
            x = nx;
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    // CORDIC vectoring for y >= 0, result clamped to zero..half-turn.
    function automatic longint vector_angle(input longint y, input longint x);
        longint z, nx, t;
        z = 0;
        if (x < 0) begin
            t = x; x = y; y = -t; z = Quarter;
        end
        for (int i = 0; i < Steps; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); y = y - (x >>> i); z += longint'(gcrd_pkg::AtanUnits[i]);
            end else begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(gcrd_pkg::AtanUnits[i]);
            end
            x = nx;
        end
        if (z < 0) z = 0;
        if (z > Half) z = Half;
        return z;
    endfunction

    function automatic bit [63:0] floor_sqrt(input bit [63:0] v);
        bit [63:0] r, b;
        r = 0; b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    // Vincenty central angle between two waypoints, in half-turn units.
    function automatic bit [63:0] central_angle(input longint la1, input longint lo1,
                                                input longint la2, input longint lo2);
        longint s1, c1, s2, c2, sd, cd, t, a, b, den;
        bit [31:0] dlon;
        bit [63:0] ua, ub;
        dlon = 32'(lo2 - lo1);
        rotate_angle(la1, s1, c1);
        rotate_angle(la2, s2, c2);
        rotate_angle(longint'(signed'(dlon)), sd, cd);
        t   = q30_mul(c2, cd);
        a   = q30_mul(c1, sd);
        b   = q30_mul(c1, s2) - q30_mul(s1, t);
        den = q30_mul(s1, s2) + q30_mul(c1, t);
        ua  = a < 0 ? -a : a;
        ub  = b < 0 ? -b : b;
        return 64'(vector_angle(longint'(floor_sqrt(ua * ua + ub * ub)), den));
    endfunction

    // Work out the result of one accepted waypoint and advance the route state.
    function automatic t_route_result next_leg(input longint lat, input longint lon,
                                               input bit [16:0] h, input bit last);
        t_route_result r;
        bit [63:0] leg, hq, rad, q;
        leg = 0;
        if (route_open) begin
            hq  = (64'(last_height) * 64'd706861 + 64'd32768) >> 16;
            rad = (64'(radius_nm) << 16) + hq;
            q   = (central_angle(last_lat, last_lon, lat, lon) * rad) >> 24;
            leg = ((q * 64'd421657428 + (64'd1 << 33)) >> 34) & 64'h3FFF_FFFF;
            route_total += leg;
            if (route_total > TotalMax) route_total = TotalMax;
        end
        r.leg = leg[29:0];
        r.total = route_total[39:0];
        r.done = last;
        if (last) begin
            last_lat = 0; last_lon = 0; last_height = 0;
            route_open = 0; route_total = 0;
        end else begin
            last_lat = lat; last_lon = lon; last_height = h; route_open = 1;
        end
        return r;
    endfunction

    // Send one waypoint item; valid stays high on return.
    task automatic send_waypoint(input logic signed [31:0] lat, input logic signed [31:0] lon,
                                 input logic [16:0] h, input logic last);
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_latitude    <= lat;
        i_longitude   <= lon;
        i_height_feet <= h;
        i_route_last  <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_legs.push_back(next_leg(longint'(lat), longint'(lon), h, last));
    endtask

    // Drain outstanding results, then write the radius register.
    task automatic set_radius(input logic [11:0] value);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_legs.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        radius_nm  = value;
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 47; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 47; end
            default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
        endcase
    endtask

    // Extremes of every field, poles, antipodes, wraps and a lone waypoint.
    task automatic test_directed();
        send_waypoint(32'sd12345, -32'sd999, 17'd500, 1'b1);
        send_waypoint(0, 0, 17'd0, 1'b0);
        send_waypoint(0, 0, 17'd0, 1'b0);
        send_waypoint(32'sd1073741824, 0, 17'h1FFFF, 1'b0);
        send_waypoint(-32'sd1073741824, 32'sd77, 17'd0, 1'b0);
        send_waypoint(0, 0, 17'h1FFFF, 1'b0);
        send_waypoint(0, 32'h8000_0000, 17'h0FFFF, 1'b0);
        send_waypoint(0, 32'h7FFF_FFFF, 17'h10000, 1'b0);
        send_waypoint(32'h7FFF_FFFF, 32'h8000_0000, 17'd1, 1'b0);
        send_waypoint(32'h8000_0000, 32'h7FFF_FFFF, 17'd2, 1'b0);
        send_waypoint(32'h5555_5555, 32'hAAAA_AAAA, 17'h0AAAA, 1'b0);
        send_waypoint(32'hAAAA_AAAA, 32'h5555_5555, 17'h15555, 1'b0);
        send_waypoint(32'sd1073741823, 32'sd1, 17'd100, 1'b0);
        send_waypoint(-32'sd1073741823, -32'sd1, 17'd100, 1'b1);
        send_waypoint(0, 0, 17'd0, 1'b1);
    endtask

    // Random well-formed routes; a few latitudes are taken from the full range.
    task automatic test_random_routes(input int count);
        logic signed [31:0] lat, lon;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9, 0) == 0) lat = $urandom;
            else lat = $signed($urandom_range(32'h8000_0000, 0)) - 32'sd1073741824;
            lon = $urandom;
            send_waypoint(lat, lon, 17'($urandom), $urandom_range(5, 0) == 0);
        end
        send_waypoint(32'($urandom_range(1000, 0)), $urandom, 17'($urandom), 1'b1);
    endtask

    // One long route of near-antipodal hops at the largest radius, so the total saturates.
    task automatic test_saturation(input int hops);
        logic signed [31:0] lon;
        lon = $urandom;
        for (int n = 0; n < hops; n++) begin
            lon = lon + 32'h8000_0000 + 32'($urandom_range(3, 0)) - 32'sd1;
            send_waypoint(32'($urandom_range(7, 0)), lon, 17'h1FFFF - 17'($urandom_range(7, 0)),
                          1'b0);
        end
        send_waypoint(0, lon, 17'd0, 1'b1);
    endtask

    // Receiver: random stall, and check each accepted result item against the oldest one.
    always @(posedge i_clk) begin
        t_route_result want;
        if (o_out_valid && !i_out_stall && i_rst_n) begin
            if (pending_legs.size() == 0) begin
                $display("%0t: unexpected result leg=%0d total=%0d done=%0d", $realtime,
                         o_leg_distance, o_total_distance, o_route_done);
                mismatches++;
            end else begin
                want = pending_legs.pop_front();
                if (o_leg_distance !== want.leg) begin
                    $display("%0t: leg_distance expected %0d actual %0d", $realtime,
                             want.leg, o_leg_distance);
                    mismatches++;
                end
                if (o_total_distance !== want.total) begin
                    $display("%0t: total_distance expected %0d actual %0d", $realtime,
                             want.total, o_total_distance);
                    mismatches++;
                end
                if (o_route_done !== want.done) begin
                    $display("%0t: route_done expected %0d actual %0d", $realtime,
                             want.done, o_route_done);
                    mismatches++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
    end

    // Watchdog on cycles with no item moving on any port.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we ||
            !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        last_lat = 0; last_lon = 0; last_height = 0; route_open = 0; route_total = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(0);
        test_directed();
        set_radius(12'd0);
        set_idling(1);
        test_random_routes(60);
        set_radius(12'd4095);
        set_idling(2);
        test_directed();
        set_idling(3);
        test_saturation(1320);
        for (int p = 0; p < 4; p++) begin
            set_radius(p == 0 ? 12'd3000 : p == 1 ? 12'd4000 : 12'($urandom));
            set_idling(p);
            test_random_routes(108);
        end

        i_in_valid <= 1'b0;
        while (pending_legs.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
